FILE: design/earliest_free_worker_dispatch_unit_assert.svh
// Assertion macros shared by the dispatch unit. Each use checks on the rising
// clock edge and is switched off while reset is asserted.
`ifndef EARLIEST_FREE_WORKER_DISPATCH_UNIT_ASSERT_SVH
`define EARLIEST_FREE_WORKER_DISPATCH_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define EFWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true outside reset.
`define EFWD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: design/efwd_pkg.sv
package efwd_pkg;

  localparam int TIME_W          = 48;
  localparam int DUR_W           = 32;
  localparam int CFG_W           = 5;
  localparam int WORKER_W        = 4;
  localparam int NUM_WORKERS_DEF = 16;

  localparam logic [CFG_W-1:0] NUM_WORKERS_RST = CFG_W'(16);

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] ftime;
  } sweep_t;

  // Free-time update broadcast to all cells at the end of a sweep.
  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] ftime;
  } wr_t;

endpackage

FILE: design/efwd_cell.sv
// One worker slot: holds the worker's free time and folds it into the running
// minimum that passes by, one cell per cycle.
module efwd_cell #(
  parameter int NUM_WORKERS = efwd_pkg::NUM_WORKERS_DEF,
  parameter int IDX         = 0,
  localparam int IdxW       = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic [efwd_pkg::CFG_W-1:0]  num_workers_i,
  input  efwd_pkg::sweep_t            sweep_i,
  input  logic [IdxW-1:0]             best_idx_i,
  output efwd_pkg::sweep_t            sweep_o,
  output logic [IdxW-1:0]             best_idx_o,
  input  efwd_pkg::wr_t               wr_i,
  input  logic [IdxW-1:0]             wr_idx_i
);

  logic [efwd_pkg::TIME_W-1:0] time_q;
  logic                        carry_valid_q;
  logic [efwd_pkg::TIME_W-1:0] carry_time_q;
  logic [IdxW-1:0]             carry_idx_q;
  logic                        active;
  logic                        take;

  // Worker zero is always in use; the others only below the configured count.
  assign active = (IDX == 0) || (32'(IDX) < 32'(num_workers_i));
  // Strict less-than keeps the lower index on a tie.
  assign take   = active && ((IDX == 0) || (time_q < sweep_i.ftime));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q        <= '0;
      carry_valid_q <= 1'b0;
    end else begin
      carry_valid_q <= sweep_i.valid;
      priority if (clear_i) begin
        time_q <= '0;
      end else if (wr_i.en && (wr_idx_i == IdxW'(IDX))) begin
        time_q <= wr_i.ftime;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      carry_time_q <= time_q;
      carry_idx_q  <= IdxW'(IDX);
    end else begin
      carry_time_q <= sweep_i.ftime;
      carry_idx_q  <= best_idx_i;
    end
  end

  assign sweep_o.valid = carry_valid_q;
  assign sweep_o.ftime = carry_time_q;
  assign best_idx_o    = carry_idx_q;

endmodule

FILE: design/earliest_free_worker_dispatch_unit.sv
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_stall_o   duration_i, new_batch_i
// out       output     out_valid_o / out_stall_i worker_o, start_time_o
// cfg       input      cfg_we_i                  cfg_wdata_i (worker count)
//
// One job is in flight at a time. The minimum search walks the cell chain one
// cell per cycle, and the next job can be taken only after the last one's sweep
// has finished.
// Reset clears every free time to zero and sets the worker count to 16.
// A finished result waits in the output register; a second one can wait in a
// skid register, and only that second one holds off new jobs.
`include "earliest_free_worker_dispatch_unit_assert.svh"

module earliest_free_worker_dispatch_unit #(
  parameter int NUM_WORKERS = efwd_pkg::NUM_WORKERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [efwd_pkg::DUR_W-1:0]     duration_i,
  input  logic                           new_batch_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [efwd_pkg::WORKER_W-1:0]  worker_o,
  output logic [efwd_pkg::TIME_W-1:0]    start_time_o,
  input  logic                           cfg_we_i,
  input  logic [efwd_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int IdxW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

  logic [efwd_pkg::CFG_W-1:0]    num_workers_q;
  logic                          busy_q;
  logic                          launch_q;
  logic [efwd_pkg::DUR_W-1:0]    dur_q;
  logic                          in_acc;
  logic                          clear;

  // The running minimum enters at slot zero and leaves after the last cell.
  efwd_pkg::sweep_t              chain_sweep [NUM_WORKERS+1];
  logic [IdxW-1:0]               chain_idx   [NUM_WORKERS+1];
  efwd_pkg::wr_t                 wr;
  logic [IdxW-1:0]               wr_idx;

  logic                          fin;
  logic [efwd_pkg::TIME_W-1:0]   fin_start;
  logic [efwd_pkg::TIME_W:0]     fin_sum;
  logic [31:0]                   fin_idx_ext;
  logic [efwd_pkg::WORKER_W-1:0] fin_worker;

  logic                          out_valid_q;
  logic [efwd_pkg::WORKER_W-1:0] out_worker_q;
  logic [efwd_pkg::TIME_W-1:0]   out_start_q;
  logic                          skid_valid_q;
  logic [efwd_pkg::WORKER_W-1:0] skid_worker_q;
  logic [efwd_pkg::TIME_W-1:0]   skid_start_q;
  logic                          out_free;

  assign in_stall_o = busy_q || skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  // A new batch zeroes every slot at the accept edge, before slot zero looks at it.
  assign clear      = in_acc && new_batch_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_workers_q <= efwd_pkg::NUM_WORKERS_RST;
      busy_q        <= 1'b0;
      launch_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_workers_q <= cfg_wdata_i;
      end
      launch_q <= in_acc;
      priority if (in_acc) begin
        busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dur_q <= duration_i;
    end
  end

  assign chain_sweep[0].valid = launch_q;
  assign chain_sweep[0].ftime = '0;
  assign chain_idx[0]         = '0;

  for (genvar k = 0; k < NUM_WORKERS; k++) begin : g_cell
    efwd_cell #(
      .NUM_WORKERS (NUM_WORKERS),
      .IDX         (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .clear_i       (clear),
      .num_workers_i (num_workers_q),
      .sweep_i       (chain_sweep[k]),
      .best_idx_i    (chain_idx[k]),
      .sweep_o       (chain_sweep[k+1]),
      .best_idx_o    (chain_idx[k+1]),
      .wr_i          (wr),
      .wr_idx_i      (wr_idx)
    );
  end

  // The sweep is done when the minimum falls out of the last cell. The winner's
  // old free time is the start time, and its new free time saturates at the top.
  assign fin         = chain_sweep[NUM_WORKERS].valid;
  assign fin_start   = chain_sweep[NUM_WORKERS].ftime;
  assign fin_sum     = {1'b0, fin_start} + (efwd_pkg::TIME_W+1)'(dur_q);
  assign fin_idx_ext = 32'(chain_idx[NUM_WORKERS]);
  assign fin_worker  = fin_idx_ext[efwd_pkg::WORKER_W-1:0];

  assign wr.en    = fin;
  assign wr.ftime = fin_sum[efwd_pkg::TIME_W] ? '1 : fin_sum[efwd_pkg::TIME_W-1:0];
  assign wr_idx   = chain_idx[NUM_WORKERS];

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        priority if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else if (fin) begin
          out_valid_q  <= 1'b1;
        end else begin
          out_valid_q  <= 1'b0;
        end
      end else if (fin) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_worker_q <= skid_worker_q;
        out_start_q  <= skid_start_q;
      end else if (fin) begin
        out_worker_q <= fin_worker;
        out_start_q  <= fin_start;
      end
    end else if (fin) begin
      skid_worker_q <= fin_worker;
      skid_start_q  <= fin_start;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign worker_o     = out_worker_q;
  assign start_time_o = out_start_q;

  // The skid register only fills behind a waiting output word.
  `EFWD_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  // A sweep only finishes while a job is in flight.
  `EFWD_ASSERT(a_fin_when_busy, fin |-> busy_q, "sweep finished with no job in flight")
  // A taken job starts a sweep in the following cycle.
  `EFWD_ASSERT(a_launch_after_acc, in_acc |=> (busy_q && launch_q), "accepted job did not launch")
  // No result can arrive while the skid register is still occupied.
  `EFWD_ASSERT_NEVER(a_no_fin_on_skid, fin && skid_valid_q, "result would overrun skid")

endmodule

FILE: dv/efwd_dispatch_checker.sv
module efwd_dispatch_checker #(
  parameter int NUM_WORKERS = efwd_pkg::NUM_WORKERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [efwd_pkg::DUR_W-1:0]     duration_i,
  input  logic                           new_batch_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [efwd_pkg::WORKER_W-1:0]  worker_i,
  input  logic [efwd_pkg::TIME_W-1:0]    start_time_i,
  input  logic                           cfg_we_i,
  input  logic [efwd_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                             mismatch_cnt_o,
  output int                             jobs_open_o
);

  localparam int TimeW   = efwd_pkg::TIME_W;
  localparam int DurW    = efwd_pkg::DUR_W;
  localparam int WorkerW = efwd_pkg::WORKER_W;

  typedef struct packed {
    logic [WorkerW-1:0] worker;
    logic [TimeW-1:0]   start;
  } assignment_t;

  logic [TimeW-1:0]            free_at [NUM_WORKERS];
  logic [efwd_pkg::CFG_W-1:0]  worker_cfg;
  assignment_t                 assignment_q [$];

  // Picks the earliest free active worker, ties to the lowest index, and books the job.
  function automatic assignment_t dispatch_job(input logic [DurW-1:0] dur,
                                               input logic fresh);
    assignment_t    res;
    int             active;
    int             best;
    logic [TimeW:0] sum;
    active = worker_cfg;
    if (active == 0) active = 1;
    if (active > NUM_WORKERS) active = NUM_WORKERS;
    if (fresh) begin
      foreach (free_at[k]) free_at[k] = '0;
    end
    best = 0;
    for (int k = 1; k < active; k++) begin
      if (free_at[k] < free_at[best]) best = k;
    end
    res.worker = WorkerW'(best);
    res.start  = free_at[best];
    sum = {1'b0, free_at[best]} + (TimeW+1)'(dur);
    free_at[best] = sum[TimeW] ? '1 : sum[TimeW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    assignment_t want;
    int          errs;
    if (!rst_ni) begin
      foreach (free_at[k]) free_at[k] = '0;
      worker_cfg = efwd_pkg::NUM_WORKERS_RST;
      assignment_q.delete();
      mismatch_cnt_o <= 0;
      jobs_open_o    <= 0;
    end else begin
      errs = 0;
      if (out_valid_i && !out_stall_i) begin
        if (assignment_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got worker %0d start %0d",
                   $time, worker_i, start_time_i);
          errs++;
        end else begin
          want = assignment_q.pop_front();
          if (worker_i !== want.worker) begin
            $display("%0t: worker expected %0d, got %0d", $time, want.worker, worker_i);
            errs++;
          end
          if (start_time_i !== want.start) begin
            $display("%0t: start_time expected %0d, got %0d",
                     $time, want.start, start_time_i);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        assignment_q = {assignment_q, dispatch_job(duration_i, new_batch_i)};
      end
      if (cfg_we_i) begin
        worker_cfg = cfg_wdata_i;
      end
      mismatch_cnt_o <= mismatch_cnt_o + errs;
      jobs_open_o    <= assignment_q.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the earliest-free-worker dispatch unit.
// This module only makes stimulus and gives the verdict. The checker beside the
// block watches both channels and the configuration port, keeps its own copy of
// the worker free times and compares every result word with its prediction.
module tb_top;

  localparam int DurW    = efwd_pkg::DUR_W;
  localparam int WorkerW = efwd_pkg::WORKER_W;
  localparam int TimeW   = efwd_pkg::TIME_W;
  localparam int CfgW    = efwd_pkg::CFG_W;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [DurW-1:0]    duration_i  = '0;
  logic               new_batch_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WorkerW-1:0] worker_o;
  logic [TimeW-1:0]   start_time_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  int mismatches;
  int jobs_open;

  // Idling controls. The sender's gaps are local to the stimulus process, while
  // the receiver's stall pattern runs in its own process and is gated by stall_on.
  bit gaps_on  = 1'b1;
  bit stall_on = 1'b0;
  int stall_hold;

  always #10 clk_i = ~clk_i;

  earliest_free_worker_dispatch_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .duration_i   (duration_i),
    .new_batch_i  (new_batch_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .worker_o     (worker_o),
    .start_time_o (start_time_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  efwd_dispatch_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .duration_i     (duration_i),
    .new_batch_i    (new_batch_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .worker_i       (worker_o),
    .start_time_i   (start_time_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatches),
    .jobs_open_o    (jobs_open)
  );

  // Length of an idle stretch: mostly none or a short one, now and then a long one
  // that can cover a whole search through the cell chain.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Job durations lean toward zero and small values so that equal free times, and
  // with them the lowest-index tie break, come up often. Full-range values make
  // sure that every duration bit is seen at both levels.
  function automatic logic [DurW-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 60) return DurW'($urandom_range(1, 16));
    if (r < 80) return DurW'($urandom_range(0, 1000));
    return DurW'($urandom());
  endfunction

  // The receiver holds each stall level for a random stretch. When stall_on is
  // clear the output channel never pushes back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (!stall_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_hold  <= idle_len();
    end
  end

  // Offers one job word and waits for the edge at which it is taken. The valid
  // stays high into the next word unless a gap is drawn, so back-to-back words
  // never lower and raise valid in the same step.
  task automatic send_job(input logic [DurW-1:0] dur, input logic fresh);
    int gap;
    in_valid_i  <= 1'b1;
    duration_i  <= dur;
    new_batch_i <= fresh;
    do @(posedge clk_i); while (in_stall_o);
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drops valid and waits until the checker has seen every predicted word come
  // back. Every job yields exactly one word, so after this the block is idle.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (jobs_open != 0);
  endtask

  task automatic write_workers(input logic [CfgW-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Worker counts for the first random phases: the zero and over-range settings
  // that get clamped, a single worker, the full and the reset count, and two in between.
  int unsigned phase_cfg [7] = '{1, 0, 31, 16, 17, 2, 7};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, run with the reset worker count of 16. All free times start
    // equal, so the first jobs walk up from worker 0 by the tie break.
    gaps_on = 1'b0;
    send_job('0, 1'b0);
    send_job('1, 1'b0);
    send_job(DurW'(5), 1'b0);
    send_job(DurW'(1), 1'b0);
    // A new batch clears every free time before the job is placed.
    send_job(DurW'(7), 1'b1);
    send_job(DurW'(32'h8000_0000), 1'b0);
    send_job(DurW'(32'h7FFF_FFFF), 1'b0);
    for (int k = 3; k < 16; k++) send_job(DurW'(3), 1'b0);
    send_job(DurW'(10), 1'b0);
    wait_quiet();
    // A count of zero acts as a single worker, a count far above the maximum as
    // all of them.
    write_workers(CfgW'(0));
    send_job(DurW'(4), 1'b0);
    wait_quiet();
    write_workers(CfgW'(31));
    send_job(DurW'(2), 1'b0);
    wait_quiet();

    // A small count leaves the upper workers idle with the times they hold.
    write_workers(CfgW'(3));
    send_job(DurW'(9), 1'b0);
    send_job(DurW'(9), 1'b0);
    wait_quiet();

    // Random phases. Each picks a worker count and its own idling mix; workers
    // left out of a phase keep their times until a later phase brings them back.
    for (int p = 0; p < 13; p++) begin
      write_workers(p < 7 ? CfgW'(phase_cfg[p]) : CfgW'($urandom_range(0, 31)));
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on <= ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 48; k++) begin
        send_job(pick_duration(), $urandom_range(0, 11) == 0);
      end
      wait_quiet();
    end

    repeat (efwd_pkg::NUM_WORKERS_DEF + 4) @(posedge clk_i);
    if (mismatches == 0 && jobs_open == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // A run that has not finished by this time is called hung; the limit leaves ample
  // room for the slowest correct run, even with the longest gaps and stalls on every word.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
